// ===== design/hlbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hlbc_pkg
// Shared types, constants and fixed-point helpers for the D2Q7 collision core.
// ----------------------------------------------------------------------------
`default_nettype none

package hlbc_pkg;

  localparam int W   = 16;
  localparam int F   = W - 2;
  localparam int AW  = 2 * W + 4;
  localparam int NW  = W + F;
  localparam int DCW = NW + 1;
  localparam int DW  = W + 2;
  localparam int PW  = 2 * W + 3;
  localparam int RCW = W + 1;
  localparam int ND  = 7;
  localparam int NM  = 6;

  typedef logic signed [W-1:0]  val_t;
  typedef logic signed [AW-1:0] acc_t;

  localparam val_t VMAX = {1'b0, {(W-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(W-1){1'b0}}};

  localparam int ONE_Q    = 1 << F;
  localparam int HALF_LSB = 1 << (F - 1);

  localparam logic [W-2:0] REST_RESET  = (W-1)'(ONE_Q / 2);
  localparam logic [W-2:0] RELAX_RESET = (W-1)'(ONE_Q);
  localparam val_t         DRIVE_RESET = val_t'((7 * ONE_Q + 500) / 1000);

  localparam logic [63:0] SIN60_L = (64'd3719550787 + (64'd1 << (31 - F))) >> (32 - F);
  localparam val_t        SIN60   = val_t'(SIN60_L);

  localparam logic [RCW-1:0] RECIP3 = RCW'(((64'd1 << (W + 2)) + 64'd2) / 3);
  localparam logic [RCW-1:0] RECIP6 = RCW'(((64'd1 << (W + 3)) + 64'd5) / 6);

  localparam logic signed [2:0] COS2 [NM] = '{3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd1, 3'sd1};
  localparam logic signed [2:0] SSGN [NM] = '{3'sd0, 3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd1};
  localparam int                OPP  [NM] = '{3, 4, 5, 0, 1, 2};

  typedef enum logic [1:0] {
    KIND_SOLID = 2'd0,
    KIND_WALL  = 2'd1,
    KIND_FLUID = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_REST_WEIGHT = 2'd0,
    CFG_RELAX_RATE  = 2'd1,
    CFG_DRIVE_FORCE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic            drive;
    val_t            rho;
    val_t            ux;
    val_t            uy;
    val_t [ND-1:0]   f;
  } ctx_t;

  function automatic val_t sat(input acc_t x);
    if (x > acc_t'(VMAX)) begin
      return VMAX;
    end else if (x < acc_t'(VMIN)) begin
      return VMIN;
    end
    return val_t'(x);
  endfunction

  function automatic val_t mulq(input val_t a, input val_t b);
    acc_t p;
    p = acc_t'(a) * acc_t'(b) + acc_t'(HALF_LSB);
    return sat(p >>> F);
  endfunction

  function automatic acc_t divr3(input acc_t x);
    logic [DW-1:0] n;
    logic [PW-1:0] p;
    acc_t          q;
    n = x[AW-1] ? DW'(-x) : DW'(x);
    n = n + DW'(1);
    p = PW'(n) * PW'(RECIP3);
    q = acc_t'(p >> (W + 2));
    return x[AW-1] ? -q : q;
  endfunction

  function automatic acc_t divr6(input acc_t x);
    logic [DW-1:0] n;
    logic [PW-1:0] p;
    acc_t          q;
    n = x[AW-1] ? DW'(-x) : DW'(x);
    n = n + DW'(3);
    p = PW'(n) * PW'(RECIP6);
    q = acc_t'(p >> (W + 3));
    return x[AW-1] ? -q : q;
  endfunction

endpackage

`default_nettype wire

// ===== design/hlbc_div.sv =====
// ----------------------------------------------------------------------------
// hlbc_div
// Pipelined restoring divider: round(num * 2^F / den), saturated, one bit
// per stage. Zero when den <= 0.
// ----------------------------------------------------------------------------
`default_nettype none

module hlbc_div import hlbc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  val_t num_i,
  input  val_t den_i,
  output val_t quo_o
);

  logic [W-1:0]  mabs;
  logic [NW-1:0] nr;

  logic [NW-1:0] rem_q  [0:W];
  logic [W-1:0]  q_q    [0:W];
  logic [W-2:0]  d_q    [0:W];
  logic          neg_q  [0:W];
  logic          zero_q [0:W];
  logic          ovf_q  [0:W];
  val_t          quo_q;
  val_t          quo_d;

  always_comb begin
    mabs = num_i[W-1] ? W'(-num_i) : W'(num_i);
    nr   = (NW'(mabs) << F) + NW'(den_i[W-2:1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= nr;
      q_q[0]    <= '0;
      d_q[0]    <= den_i[W-2:0];
      neg_q[0]  <= num_i[W-1];
      zero_q[0] <= den_i[W-1] || (den_i == '0);
      ovf_q[0]  <= DCW'(nr) >= (DCW'(den_i[W-2:0]) << W);
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_bit
    localparam int B = W - 1 - j;
    logic [DCW-1:0] trial;
    logic           take;
    assign trial = DCW'(d_q[j]) << B;
    assign take  = DCW'(rem_q[j]) >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= take ? NW'(DCW'(rem_q[j]) - trial) : rem_q[j];
        q_q[j+1]    <= q_q[j] | (W'(take) << B);
        d_q[j+1]    <= d_q[j];
        neg_q[j+1]  <= neg_q[j];
        zero_q[j+1] <= zero_q[j];
        ovf_q[j+1]  <= ovf_q[j];
      end
    end
  end

  always_comb begin
    if (zero_q[W]) begin
      quo_d = '0;
    end else if (ovf_q[W]) begin
      quo_d = neg_q[W] ? VMIN : VMAX;
    end else if (!neg_q[W]) begin
      quo_d = q_q[W][W-1] ? VMAX : val_t'(q_q[W]);
    end else begin
      quo_d = (q_q[W] > {1'b1, {(W-1){1'b0}}}) ? VMIN : -val_t'(q_q[W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ===== design/hlbc_eq.sv =====
// ----------------------------------------------------------------------------
// hlbc_eq
// Equilibrium lane for one moving direction.
// ----------------------------------------------------------------------------
`default_nettype none

module hlbc_eq import hlbc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  val_t ev_i,
  input  val_t rho_i,
  input  val_t t0_i,
  input  val_t t3_i,
  output val_t eq_o
);

  val_t m1_q, e2_q, rho_q, t1_q, m2_q, t2_q, t1b_q, eq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= mulq(rho_i, ev_i);
      e2_q  <= mulq(ev_i, ev_i);
      rho_q <= rho_i;
      t1_q  <= val_t'(divr3(acc_t'(m1_q)));
      m2_q  <= mulq(rho_q, e2_q);
      t2_q  <= val_t'(divr3(acc_t'(m2_q) <<< 1));
      t1b_q <= t1_q;
      eq_q  <= sat(acc_t'(t0_i) + acc_t'(t1b_q) + acc_t'(t2_q) - acc_t'(t3_i));
    end
  end

  assign eq_o = eq_q;

endmodule

`default_nettype wire

// ===== design/hlbc_relax.sv =====
// ----------------------------------------------------------------------------
// hlbc_relax
// BGK relaxation lane: new f = f + rate * (eq - f), plus optional forcing.
// ----------------------------------------------------------------------------
`default_nettype none

module hlbc_relax import hlbc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  val_t eq_i,
  input  val_t f_i,
  input  logic drive_i,
  input  val_t force_i,
  input  val_t rr_i,
  output val_t nf_o
);

  val_t diff_q, f1_q, delta_q, f2_q, nf_q;
  logic drv1_q, drv2_q;
  val_t dsum;

  assign dsum = drv2_q ? sat(acc_t'(delta_q) + acc_t'(force_i)) : delta_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= sat(acc_t'(eq_i) - acc_t'(f_i));
      f1_q    <= f_i;
      drv1_q  <= drive_i;
      delta_q <= mulq(diff_q, rr_i);
      f2_q    <= f1_q;
      drv2_q  <= drv1_q;
      nf_q    <= sat(acc_t'(f2_q) + acc_t'(dsum));
    end
  end

  assign nf_o = nf_q;

endmodule

`default_nettype wire

// ===== design/hex_lattice_boltzmann_collision_core.sv =====
// ----------------------------------------------------------------------------
// hex_lattice_boltzmann_collision_core
// D2Q7 BGK collision for one lattice cell per word.
// ----------------------------------------------------------------------------
//  channel   dir  width      contents
//  s_axis    in   112 + 3    tdata f0..f6, tuser kind/drive
//  m_axis    out  144        tdata new f0..f6, ux, uy
//  cfg       in   2 + 16     register index, write data
//
//  One word per cycle unless m_axis stalls; m_axis_tvalid rises when the word
//  leaves the pipeline. The velocity divider takes one quotient bit per stage.
//  A stall on m_axis freezes the whole pipeline and drops s_axis_tready.
//  Reset clears the valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_lattice_boltzmann_collision_core import hlbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ND*W-1:0]     s_axis_tdata,  // density_east..density_rest
  input  logic [2:0]          s_axis_tuser,  // cell_kind, on_drive_column
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [(ND+2)*W-1:0] m_axis_tdata,  // new_east..new_rest, velocity_x, _y
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [W-1:0]        cfg_data_i
);

  localparam int NS  = 30;
  localparam int PSW = 2 * W;

  logic          en;
  logic [NS:1]   vld_q;
  logic [W-2:0]  rw_q, rr_q;
  val_t          df_q;
  val_t          force_q [NM];
  val_t          rwv, rrv;

  val_t          fin [ND];
  acc_t          rsum, mx2, sy;
  ctx_t          ctx1_d;
  ctx_t          ctx21_d;
  ctx_t          ctx_q [1:29];
  val_t          mx1_q, mx2_q, my_q;
  logic signed [W+1:0] sy_q;
  val_t          div_x, div_y;
  val_t          pux_q, puy_q;
  logic signed [PSW-1:0] psy_q;
  val_t          usq_q, ma_q, moma_q, ma23_q, ru_q;
  val_t          ev_q [NM];
  val_t          t0_23_q, t0_24_q, t0_25_q, t3_24_q, t3_25_q;
  val_t          eqr24_q, eqr25_q, eqr26_q;
  val_t          eq_w [NM];
  val_t          nf_w [ND];
  val_t          out_q [ND+2];

  assign en            = !vld_q[NS] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NS];
  assign cfg_ready_o   = 1'b1;
  assign rwv           = val_t'({1'b0, rw_q});
  assign rrv           = val_t'({1'b0, rr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-1:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q <= REST_RESET;
      rr_q <= RELAX_RESET;
      df_q <= DRIVE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REST_WEIGHT: rw_q <= cfg_data_i[W-2:0];
        CFG_RELAX_RATE:  rr_q <= cfg_data_i[W-2:0];
        CFG_DRIVE_FORCE: df_q <= val_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < NM; d++) begin
      force_q[d] <= val_t'(divr6(acc_t'(df_q) * acc_t'(COS2[d])));
    end
  end

  always_comb begin
    for (int d = 0; d < ND; d++) begin
      fin[d] = val_t'(s_axis_tdata[d*W +: W]);
    end
    rsum = '0;
    for (int d = 0; d < ND; d++) begin
      rsum = rsum + acc_t'(fin[d]);
    end
    mx2 = (acc_t'(fin[0]) <<< 1) - (acc_t'(fin[3]) <<< 1) + acc_t'(fin[1]) + acc_t'(fin[5])
        - acc_t'(fin[2]) - acc_t'(fin[4]);
    sy  = acc_t'(fin[1]) + acc_t'(fin[2]) - acc_t'(fin[4]) - acc_t'(fin[5]);
    ctx1_d.kind  = s_axis_tuser[1:0];
    ctx1_d.drive = s_axis_tuser[2];
    ctx1_d.rho   = sat(rsum);
    ctx1_d.ux    = '0;
    ctx1_d.uy    = '0;
    for (int d = 0; d < ND; d++) begin
      ctx1_d.f[d] = fin[d];
    end
  end

  always_comb begin
    ctx21_d    = ctx_q[20];
    ctx21_d.ux = div_x;
    ctx21_d.uy = div_y;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[1] <= ctx1_d;
      for (int k = 2; k <= 20; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end
      ctx_q[21] <= ctx21_d;
      for (int k = 22; k <= 29; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end
      mx1_q <= sat((mx2 + acc_t'(1)) >>> 1);
      sy_q  <= (W+2)'(sy);
      mx2_q <= mx1_q;
      my_q  <= sat((acc_t'(SIN60) * acc_t'(sy_q) + acc_t'(HALF_LSB)) >>> F);
      pux_q <= mulq(div_x, div_x);
      puy_q <= mulq(div_y, div_y);
      psy_q <= PSW'(acc_t'(SIN60) * acc_t'(div_y));
      usq_q <= sat(acc_t'(pux_q) + acc_t'(puy_q));
      for (int d = 0; d < NM; d++) begin
        ev_q[d] <= sat((((acc_t'(COS2[d]) * acc_t'(ctx_q[21].ux)) <<< (F - 1))
                      + acc_t'(SSGN[d]) * acc_t'(psy_q) + acc_t'(HALF_LSB)) >>> F);
      end
      ma_q    <= mulq(rwv, ctx_q[21].rho);
      moma_q  <= mulq(val_t'(ONE_Q) - rwv, ctx_q[21].rho);
      ru_q    <= mulq(ctx_q[22].rho, usq_q);
      t0_23_q <= val_t'(divr6(acc_t'(moma_q)));
      ma23_q  <= ma_q;
      t3_24_q <= val_t'(divr6(acc_t'(ru_q)));
      eqr24_q <= sat(acc_t'(ma23_q) - acc_t'(ru_q));
      t0_24_q <= t0_23_q;
      t0_25_q <= t0_24_q;
      t3_25_q <= t3_24_q;
      eqr25_q <= eqr24_q;
      eqr26_q <= eqr25_q;
    end
  end

  hlbc_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mx2_q),
    .den_i (ctx_q[2].rho),
    .quo_o (div_x)
  );

  hlbc_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (my_q),
    .den_i (ctx_q[2].rho),
    .quo_o (div_y)
  );

  for (genvar d = 0; d < NM; d++) begin : g_move
    hlbc_eq u_eq (
      .clk_i (clk_i),
      .en_i  (en),
      .ev_i  (ev_q[d]),
      .rho_i (ctx_q[22].rho),
      .t0_i  (t0_25_q),
      .t3_i  (t3_25_q),
      .eq_o  (eq_w[d])
    );

    hlbc_relax u_relax (
      .clk_i   (clk_i),
      .en_i    (en),
      .eq_i    (eq_w[d]),
      .f_i     (ctx_q[26].f[d]),
      .drive_i (ctx_q[26].drive),
      .force_i (force_q[d]),
      .rr_i    (rrv),
      .nf_o    (nf_w[d])
    );
  end

  hlbc_relax u_relax_rest (
    .clk_i   (clk_i),
    .en_i    (en),
    .eq_i    (eqr26_q),
    .f_i     (ctx_q[26].f[ND-1]),
    .drive_i (1'b0),
    .force_i ('0),
    .rr_i    (rrv),
    .nf_o    (nf_w[ND-1])
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      case (kind_e'(ctx_q[29].kind))
        KIND_FLUID: begin
          for (int d = 0; d < ND; d++) begin
            out_q[d] <= nf_w[d];
          end
          out_q[ND]   <= ctx_q[29].ux;
          out_q[ND+1] <= ctx_q[29].uy;
        end
        KIND_WALL: begin
          for (int d = 0; d < NM; d++) begin
            out_q[d] <= ctx_q[29].f[OPP[d]];
          end
          out_q[ND-1] <= ctx_q[29].f[ND-1];
          out_q[ND]   <= '0;
          out_q[ND+1] <= '0;
        end
        default: begin
          for (int d = 0; d < ND; d++) begin
            out_q[d] <= ctx_q[29].f[d];
          end
          out_q[ND]   <= '0;
          out_q[ND+1] <= '0;
        end
      endcase
    end
  end

  always_comb begin
    for (int d = 0; d < ND + 2; d++) begin
      m_axis_tdata[d*W +: W] = out_q[d];
    end
  end

endmodule

`default_nettype wire

// ===== design/hlbc_chk.sv =====
// ----------------------------------------------------------------------------
// hlbc_chk
// Port-level checks for the collision core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hlbc_chk import hlbc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [(ND+2)*W-1:0] m_axis_tdata
);

  a_reset_clears: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

endmodule

bind hex_lattice_boltzmann_collision_core hlbc_chk u_hlbc_chk (.*);

`default_nettype wire
